// ===== src/text_mode_console_writer_core_defines.svh =====
// Assertion shorthands for the console writer checker.
`ifndef TEXT_MODE_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_CORE_DEFINES_SVH

// ante implies cons in the same cycle
`define TMCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmcw check failed");

// ante implies cons in the next cycle
`define TMCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmcw check failed");

`endif

// ===== src/tmcw_pkg.sv =====
`default_nettype none
package tmcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int LINE_W = 6;

  typedef enum logic [2:0] {
    REQ_BYTE   = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_SETCUR = 3'd2,
    REQ_SCROLL = 3'd3,
    REQ_COLOR  = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    K_NOP, K_PRINT, K_NEWLINE, K_CLEAR, K_SETCUR, K_SCROLL, K_READ
  } kind_e;

  typedef enum logic [1:0] {ESC_NONE, ESC_FG, ESC_BG} esc_e;

  typedef enum logic [2:0] {
    B_IDLE, B_SWEEP, B_PLACE_RD, B_PLACE_WR, B_READ_RD, B_READ_CAP, B_RESULT
  } bstate_e;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_ESC_FG  = 8'd14;
  localparam logic [7:0] CH_ESC_BG  = 8'd15;
  localparam logic [3:0] CURSOR_FG  = 4'd7;

  // one classified command for the back end
  typedef struct packed {
    kind_e                    kind;
    logic [7:0]               ch;
    logic [7:0]               attr;
    logic                     place;
    logic [COL_W-1:0]         px;
    logic [ROW_W-1:0]         py;
    logic [LINE_W-1:0]        lines;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== src/tmcw_fifo.sv =====
`default_nettype none
module tmcw_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  tmcw_pkg::entry_t     wdata_i,
  input  wire                  pop_i,
  output tmcw_pkg::entry_t     rdata_o,
  output tmcw_pkg::qstat_t     stat_o
);
  import tmcw_pkg::*;

  entry_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign rdata_o      = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
endmodule
`default_nettype wire

// ===== src/tmcw_front.sv =====
`default_nettype none
module tmcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire  [2:0]           req_type_i,
  input  wire  [7:0]           char_byte_i,
  input  wire                  last_byte_i,
  input  wire  [6:0]           pos_x_i,
  input  wire  [4:0]           pos_y_i,
  input  wire  [4:0]           line_count_i,
  input  wire  [3:0]           new_color_i,
  input  wire                  is_foreground_i,
  input  wire                  busy_i,
  input  tmcw_pkg::qstat_t     qstat_i,
  output logic                 push_o,
  output tmcw_pkg::entry_t     entry_o
);
  import tmcw_pkg::*;

  esc_e       esc_q, esc_d;
  logic [3:0] fg_q, fg_d, bg_q, bg_d;
  logic       take;

  assign in_ready_o = !qstat_i.full && !busy_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = take;

  always_comb begin
    esc_d         = esc_q;
    fg_d          = fg_q;
    bg_d          = bg_q;
    entry_o.kind  = K_NOP;
    entry_o.ch    = char_byte_i;
    entry_o.attr  = {bg_q, fg_q};
    entry_o.place = 1'b0;
    entry_o.px    = ({1'b0, pos_x_i} > 8'(COLS - 1)) ? COL_W'(COLS - 1) : pos_x_i;
    entry_o.py    = ({1'b0, pos_y_i} > 6'(ROWS - 1)) ? ROW_W'(ROWS - 1) : pos_y_i;
    entry_o.lines = ({1'b0, line_count_i} > 6'(ROWS)) ? LINE_W'(ROWS)
                                                      : {1'b0, line_count_i};
    case (req_type_i)
      REQ_BYTE: begin
        if (esc_q != ESC_NONE) begin
          if (char_byte_i inside {[8'd16:8'd31]}) begin
            if (esc_q == ESC_FG) fg_d = char_byte_i[3:0];
            else                 bg_d = char_byte_i[3:0];
          end
          esc_d = ESC_NONE;
        end else if (char_byte_i == CH_NEWLINE) begin
          entry_o.kind = K_NEWLINE;
        end else if (char_byte_i == CH_ESC_FG) begin
          esc_d = ESC_FG;
        end else if (char_byte_i == CH_ESC_BG) begin
          esc_d = ESC_BG;
        end else if (char_byte_i inside {[8'd32:8'd127]}) begin
          entry_o.kind = K_PRINT;
        end
        if (last_byte_i) begin
          esc_d         = ESC_NONE;
          entry_o.place = 1'b1;
        end
      end
      REQ_CLEAR: begin
        entry_o.kind  = K_CLEAR;
        entry_o.place = 1'b1;
      end
      REQ_SETCUR: begin
        entry_o.kind  = K_SETCUR;
        entry_o.place = 1'b1;
      end
      REQ_SCROLL: begin
        entry_o.kind  = K_SCROLL;
        entry_o.place = 1'b1;
      end
      REQ_COLOR: begin
        if (is_foreground_i) fg_d = new_color_i;
        else                 bg_d = new_color_i;
      end
      REQ_READ: entry_o.kind = K_READ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_NONE;
      fg_q  <= 4'd15;
      bg_q  <= 4'd0;
    end else if (take) begin
      esc_q <= esc_d;
      fg_q  <= fg_d;
      bg_q  <= bg_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/tmcw_back.sv =====
`default_nettype none
module tmcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tmcw_pkg::qstat_t     qstat_i,
  input  tmcw_pkg::entry_t     entry_i,
  output logic                 pop_o,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output logic [6:0]           cursor_col_o,
  output logic [4:0]           cursor_row_o,
  output logic [10:0]          cursor_linear_o,
  output logic                 cursor_written_o,
  output logic [7:0]           cell_char_o,
  output logic [7:0]           cell_attr_o
);
  import tmcw_pkg::*;

  localparam int TOTAL = ROWS * COLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int SW    = CW + 1;

  logic [15:0] mem [TOTAL];
  logic [15:0] rdata_q;

  bstate_e state_q, state_d;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [CW-1:0]    off_q, cnt_q, pend_addr_q, rdaddr_q, cur_lin;
  logic             pend_q, pend_zero_q, place_q, read_q, init_q;
  logic [7:0]       cell_ch_q, cell_at_q;

  logic [COL_W-1:0] col_n;
  logic [ROW_W-1:0] row_n;
  logic [LINE_W-1:0] sweep_n;
  logic [SW-1:0]    src;
  logic             src_ok, sweep_done, res_take;

  logic          we;
  logic [CW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  assign cur_lin = CW'(CW'(row_q) * CW'(COLS)) + CW'(col_q);
  assign src     = SW'(cnt_q) + SW'(off_q);
  assign src_ok  = src < SW'(TOTAL);
  assign sweep_done = (cnt_q == CW'(TOTAL)) && !pend_q;
  assign res_take   = !out_valid_o || out_ready_i;
  assign busy_o     = init_q;
  assign pop_o      = (state_q == B_IDLE) && !qstat_i.empty;

  // cursor update for the popped entry
  always_comb begin
    col_n   = col_q;
    row_n   = row_q;
    sweep_n = '0;
    case (entry_i.kind)
      K_PRINT, K_NEWLINE: begin
        if (entry_i.kind == K_PRINT && ({1'b0, col_q} + 8'd1) != 8'(COLS)) begin
          col_n = col_q + COL_W'(1);
        end else begin
          col_n = '0;
          if (({1'b0, row_q} + 6'd1) == 6'(ROWS)) sweep_n = LINE_W'(1);
          else                                   row_n = row_q + ROW_W'(1);
        end
      end
      K_CLEAR: begin
        col_n   = '0;
        row_n   = '0;
        sweep_n = LINE_W'(ROWS);
      end
      K_SETCUR: begin
        col_n = entry_i.px;
        row_n = entry_i.py;
      end
      K_SCROLL: begin
        sweep_n = entry_i.lines;
        row_n   = ({1'b0, row_q} >= entry_i.lines)
                  ? ROW_W'({1'b0, row_q} - entry_i.lines) : '0;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!qstat_i.empty) begin
        if (sweep_n != '0)          state_d = B_SWEEP;
        else if (entry_i.place)     state_d = B_PLACE_RD;
        else if (entry_i.kind == K_READ) state_d = B_READ_RD;
        else                        state_d = B_RESULT;
      end
      B_SWEEP: if (sweep_done) begin
        if (place_q)     state_d = B_PLACE_RD;
        else if (init_q) state_d = B_IDLE;
        else             state_d = B_RESULT;
      end
      B_PLACE_RD: state_d = B_PLACE_WR;
      B_PLACE_WR: state_d = B_RESULT;
      B_READ_RD:  state_d = B_READ_CAP;
      B_READ_CAP: state_d = B_RESULT;
      B_RESULT:   if (res_take) state_d = B_IDLE;
      default:    state_d = B_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = cur_lin;
    wdata = {entry_i.attr, entry_i.ch};
    raddr = cur_lin;
    case (state_q)
      B_IDLE: we = pop_o && (entry_i.kind == K_PRINT);
      B_SWEEP: begin
        we    = pend_q;
        waddr = pend_addr_q;
        wdata = pend_zero_q ? 16'h0000 : rdata_q;
        raddr = src[CW-1:0];
      end
      B_PLACE_WR: begin
        we    = 1'b1;
        wdata = {rdata_q[15:12], CURSOR_FG, rdata_q[7:0]};
      end
      B_READ_RD: raddr = rdaddr_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    rdata_q <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SWEEP;
      init_q      <= 1'b1;
      off_q       <= CW'(TOTAL);
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_zero_q <= 1'b1;
      pend_addr_q <= '0;
      place_q     <= 1'b0;
      read_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        B_IDLE: if (pop_o) begin
          col_q    <= col_n;
          row_q    <= row_n;
          off_q    <= CW'(CW'(sweep_n) * CW'(COLS));
          cnt_q    <= '0;
          pend_q   <= 1'b0;
          place_q  <= entry_i.place;
          read_q   <= (entry_i.kind == K_READ);
          rdaddr_q <= CW'(CW'(entry_i.py) * CW'(COLS)) + CW'(entry_i.px);
        end
        B_SWEEP: begin
          if (cnt_q != CW'(TOTAL)) begin
            pend_q      <= 1'b1;
            pend_addr_q <= cnt_q;
            pend_zero_q <= !src_ok;
            cnt_q       <= cnt_q + CW'(1);
          end else begin
            pend_q <= 1'b0;
          end
          if (sweep_done) init_q <= 1'b0;
        end
        B_RESULT: if (res_take) out_valid_o <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE) begin
      cell_ch_q <= 8'h00;
      cell_at_q <= 8'h00;
    end else if (state_q == B_READ_CAP) begin
      cell_ch_q <= rdata_q[7:0];
      cell_at_q <= rdata_q[15:8];
    end
    if (state_q == B_RESULT && res_take) begin
      cursor_col_o     <= col_q;
      cursor_row_o     <= row_q;
      cursor_linear_o  <= LIN_W'(cur_lin);
      cursor_written_o <= place_q;
      cell_char_o      <= read_q ? cell_ch_q : 8'h00;
      cell_attr_o      <= read_q ? cell_at_q : 8'h00;
    end
  end
endmodule
`default_nettype wire

// ===== src/text_mode_console_writer_core.sv =====
// Text-mode console writer: keeps a ROWS x COLS screen of 16-bit cells
// (attribute high byte, character low byte), a cursor and fg/bg colors.
// Input channel (in_valid_i/in_ready_o): one request per beat, req_type_i
// selects byte, clear, set cursor, scroll, set color or read cell.
// Output channel (out_valid_o/out_ready_i): exactly one result beat per
// request, in order: cursor position, its linear index, whether the hardware
// cursor was moved, and the cell for a read request.
// The back end walks a screen memory with one write and one read port:
// a printable byte is written directly, a read cell reads its address,
// cursor placement reads and rewrites the cursor cell, and clear and
// scroll sweep all ROWS*COLS cells. The back end takes a new command only
// once it is done with the last; a two-entry command queue lets the input
// side run ahead by two beats. Reset: a clearing pass zeroes all
// ROWS*COLS cells, with in_ready_o low throughout.
// When the receiver stalls the result holds in the output register; the
// back end stops at its next result and the queue fills, then in_ready_o
// drops.
`default_nettype none
module text_mode_console_writer_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  req_type_i,
  input  wire  [7:0]  char_byte_i,
  input  wire         last_byte_i,
  input  wire  [6:0]  pos_x_i,
  input  wire  [4:0]  pos_y_i,
  input  wire  [4:0]  line_count_i,
  input  wire  [3:0]  new_color_i,
  input  wire         is_foreground_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_linear_o,
  output logic        cursor_written_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);
  import tmcw_pkg::*;

  entry_t q_wdata, q_rdata;
  qstat_t q_stat;
  logic   q_push, q_pop, busy;

  // front: escape/color tracking and classification
  tmcw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .req_type_i, .char_byte_i, .last_byte_i, .pos_x_i, .pos_y_i,
    .line_count_i, .new_color_i, .is_foreground_i,
    .busy_i(busy), .qstat_i(q_stat), .push_o(q_push), .entry_o(q_wdata)
  );

  tmcw_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(q_push), .wdata_i(q_wdata),
    .pop_i(q_pop), .rdata_o(q_rdata), .stat_o(q_stat)
  );

  // back: screen memory, cursor, scroll/clear sweeps, results
  tmcw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk_i, .rst_ni, .qstat_i(q_stat), .entry_i(q_rdata), .pop_o(q_pop),
    .busy_o(busy), .out_valid_o, .out_ready_i, .cursor_col_o, .cursor_row_o,
    .cursor_linear_o, .cursor_written_o, .cell_char_o, .cell_attr_o
  );
endmodule
`default_nettype wire

// ===== src/tmcw_checker.sv =====
`default_nettype none
`include "text_mode_console_writer_core_defines.svh"
module tmcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [6:0]  cursor_col_o,
  input wire [4:0]  cursor_row_o,
  input wire [10:0] cursor_linear_o,
  input wire        cursor_written_o,
  input wire [7:0]  cell_char_o,
  input wire [7:0]  cell_attr_o
);
  `TMCW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(cursor_linear_o) && $stable(cell_attr_o))
  `TMCW_ASSERT_NOW(a_cursor_range, out_valid_o, ({1'b0, cursor_col_o} < 8'(COLS)) && ({1'b0, cursor_row_o} < 6'(ROWS)))
  `TMCW_ASSERT_NOW(a_linear, out_valid_o, cursor_linear_o == 11'(32'(cursor_row_o) * COLS + 32'(cursor_col_o)))
  `TMCW_ASSERT_NOW(a_no_cell_on_move, out_valid_o && cursor_written_o, cell_char_o == 8'h00 && cell_attr_o == 8'h00)
endmodule

bind text_mode_console_writer_core tmcw_checker #(.COLS(COLS), .ROWS(ROWS)) u_tmcw_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  import tmcw_pkg::*;

  localparam int NCOLS = 80;
  localparam int NROWS = 25;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int RANDOM_ITEMS = 1425;

  // request codes the block must ignore
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // printable range and color-escape argument range
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd127;
  localparam logic [7:0] CH_COLOR_LO = 8'd16;
  localparam logic [7:0] CH_COLOR_HI = 8'd31;

  typedef struct {
    logic [2:0] req;
    logic [7:0] ch;
    logic       last;
    logic [6:0] px;
    logic [4:0] py;
    logic [4:0] lines;
    logic [3:0] color;
    logic       isfg;
  } console_req_t;

  typedef struct {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] lin;
    logic        wr;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } console_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [7:0]  char_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic [6:0]  pos_x_i = '0;
  logic [4:0]  pos_y_i = '0;
  logic [4:0]  line_count_i = '0;
  logic [3:0]  new_color_i = '0;
  logic        is_foreground_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [10:0] cursor_linear_o;
  logic        cursor_written_o;
  logic [7:0]  cell_char_o;
  logic [7:0]  cell_attr_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_mode_console_writer_core #(.COLS(NCOLS), .ROWS(NROWS)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .char_byte_i,
    .last_byte_i, .pos_x_i, .pos_y_i, .line_count_i, .new_color_i,
    .is_foreground_i, .out_valid_o, .out_ready_i, .cursor_col_o,
    .cursor_row_o, .cursor_linear_o, .cursor_written_o, .cell_char_o,
    .cell_attr_o
  );

  // ---------------------------------------------------------------------
  // Shadow console: screen, cursor, colors and escape state
  // ---------------------------------------------------------------------
  logic [15:0]  shadow_screen [NCELLS];
  int           shadow_col;
  int           shadow_row;
  logic [3:0]   shadow_fg;
  logic [3:0]   shadow_bg;
  esc_e         shadow_esc;
  console_res_t pending_results [$];

  int errors = 0;
  int beats_sent = 0;

  // Shift every row up one, blank the bottom row; cursor row floors at 0.
  task automatic shift_screen_up();
    for (int i = 0; i < NCELLS - NCOLS; i++) shadow_screen[i] = shadow_screen[i + NCOLS];
    for (int i = NCELLS - NCOLS; i < NCELLS; i++) shadow_screen[i] = '0;
    if (shadow_row > 0) shadow_row--;
  endtask

  task automatic advance_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= NROWS) shift_screen_up();
  endtask

  // Hardware cursor move: keep char and bg nibble, force fg to light gray.
  task automatic mark_cursor_cell();
    int idx;
    idx = shadow_row * NCOLS + shadow_col;
    shadow_screen[idx][11:8] = CURSOR_FG;
  endtask

  task automatic render_byte(input logic [7:0] b);
    if (shadow_esc != ESC_NONE) begin
      // escape argument: always consumed, only 16..31 picks a color
      if (b >= CH_COLOR_LO && b <= CH_COLOR_HI) begin
        if (shadow_esc == ESC_FG) shadow_fg = 4'(b - CH_COLOR_LO);
        else shadow_bg = 4'(b - CH_COLOR_LO);
      end
      shadow_esc = ESC_NONE;
    end else if (b == CH_NEWLINE) begin
      advance_line();
    end else if (b == CH_ESC_FG) begin
      shadow_esc = ESC_FG;
    end else if (b == CH_ESC_BG) begin
      shadow_esc = ESC_BG;
    end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
      shadow_screen[shadow_row * NCOLS + shadow_col] = {shadow_bg, shadow_fg, b};
      shadow_col++;
      if (shadow_col >= NCOLS) advance_line();
    end
  endtask

  // Apply one accepted request to the shadow console and queue its result.
  task automatic apply_console_req(input console_req_t r);
    console_res_t res;
    int x, y, n, idx;
    res = '{default: '0};
    x = (r.px > NCOLS - 1) ? NCOLS - 1 : r.px;
    y = (r.py > NROWS - 1) ? NROWS - 1 : r.py;
    case (r.req)
      REQ_BYTE: begin
        render_byte(r.ch);
        if (r.last) begin
          shadow_esc = ESC_NONE;   // dangling escape dies with the string
          mark_cursor_cell();
          res.wr = 1'b1;
        end
      end
      REQ_CLEAR: begin
        foreach (shadow_screen[i]) shadow_screen[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
        mark_cursor_cell();
        res.wr = 1'b1;
      end
      REQ_SETCUR: begin
        shadow_col = x;
        shadow_row = y;
        mark_cursor_cell();
        res.wr = 1'b1;
      end
      REQ_SCROLL: begin
        n = (r.lines > NROWS) ? NROWS : r.lines;
        for (int i = 0; i < n; i++) shift_screen_up();
        mark_cursor_cell();
        res.wr = 1'b1;
      end
      REQ_COLOR: begin
        if (r.isfg) shadow_fg = r.color;
        else shadow_bg = r.color;
      end
      REQ_READ: begin
        idx = y * NCOLS + x;
        res.ch = shadow_screen[idx][7:0];
        res.attr = shadow_screen[idx][15:8];
      end
      default: ;
    endcase
    res.col = 7'(shadow_col);
    res.row = 5'(shadow_row);
    res.lin = 11'(shadow_row * NCOLS + shadow_col);
    pending_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------
  // Sender: bursts of back-to-back beats with random gaps in between
  // ---------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_req(input console_req_t r);
    int gap;
    in_valid_i      <= 1'b1;
    req_type_i      <= r.req;
    char_byte_i     <= r.ch;
    last_byte_i     <= r.last;
    pos_x_i         <= r.px;
    pos_y_i         <= r.py;
    line_count_i    <= r.lines;
    new_color_i     <= r.color;
    is_foreground_i <= r.isfg;
    do @(posedge clk_i); while (!in_ready_o);
    apply_console_req(r);
    beats_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  function automatic console_req_t rand_fields();
    console_req_t r;
    r.req   = 3'($urandom_range(0, 7));
    r.ch    = 8'($urandom);
    r.last  = 1'($urandom);
    r.px    = 7'($urandom);
    r.py    = 5'($urandom);
    r.lines = 5'($urandom);
    r.color = 4'($urandom);
    r.isfg  = 1'($urandom);
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    console_req_t r;
    r = rand_fields();
    r.req = REQ_BYTE;
    r.ch = b;
    r.last = last;
    send_req(r);
  endtask

  task automatic send_cmd(input logic [2:0] req, input logic [6:0] px, input logic [4:0] py,
                          input logic [4:0] lines, input logic [3:0] color,
                          input logic isfg);
    console_req_t r;
    r = rand_fields();
    r.req = req;
    r.px = px;
    r.py = py;
    r.lines = lines;
    r.color = color;
    r.isfg = isfg;
    send_req(r);
  endtask

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------
  task automatic test_byte_classes();
    send_cmd(REQ_READ, 7'd0, 5'd0, 5'd0, 4'd0, 1'b0);  // cell after reset
    send_byte(CH_PRINT_LO, 1'b0);
    send_byte(CH_PRINT_HI, 1'b0);
    send_byte(8'd128, 1'b0);      // high half ignored
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(CH_NEWLINE, 1'b1);
  endtask

  task automatic test_color_escapes();
    send_byte(CH_ESC_FG, 1'b0);
    send_byte(CH_COLOR_LO, 1'b0);   // fg = 0
    send_byte(CH_ESC_BG, 1'b0);
    send_byte(CH_COLOR_HI, 1'b0);   // bg = 15
    send_byte(CH_ESC_FG, 1'b0);
    send_byte(8'd65, 1'b0);         // argument outside range: eaten, no color
    send_byte(CH_ESC_BG, 1'b1);     // escape dropped at end of string
    send_byte(8'd66, 1'b1);
  endtask

  task automatic test_cursor_and_screen();
    send_cmd(REQ_SETCUR, 7'h7f, 5'h1f, 5'd0, 4'd0, 1'b0);  // saturates to corner
    send_byte(8'd90, 1'b1);          // wrap at bottom right forces a scroll
    send_cmd(REQ_READ, 7'h7f, 5'h1f, 5'd0, 4'd0, 1'b0);
    send_cmd(REQ_READ, 7'd79, 5'd23, 5'd0, 4'd0, 1'b0);
    send_cmd(REQ_COLOR, 7'd0, 5'd0, 5'd0, 4'd0, 1'b1);
    send_cmd(REQ_COLOR, 7'd0, 5'd0, 5'd0, 4'd15, 1'b0);
    send_cmd(REQ_SCROLL, 7'd0, 5'd0, 5'h1f, 4'd0, 1'b0);   // count saturates
    send_cmd(REQ_SCROLL, 7'd0, 5'd0, 5'd0, 4'd0, 1'b0);    // zero still moves cursor
    send_cmd(REQ_CLEAR, 7'd0, 5'd0, 5'd0, 4'd0, 1'b0);
    send_cmd(REQ_RSVD6, 7'd3, 5'd3, 5'd3, 4'd3, 1'b1);
    send_cmd(REQ_RSVD7, 7'd3, 5'd3, 5'd3, 4'd3, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Random traffic: mostly strings with random text, escapes and newlines,
  // mixed with cursor, color and read commands; clear/scroll stay rare
  // since they walk the whole screen.
  // ---------------------------------------------------------------------
  task automatic test_random_traffic();
    int sent, len, pick;
    logic [7:0] b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 6) b = CH_NEWLINE;
          else if (pick < 12) b = $urandom_range(0, 1) ? CH_ESC_FG : CH_ESC_BG;
          else if (pick < 20) b = 8'($urandom);   // noise, any byte
          else if (pick < 26) b = 8'($urandom_range(CH_COLOR_LO, CH_COLOR_HI));
          else b = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
          send_byte(b, i == len - 1);
        end
        sent += len;
      end else begin
        console_req_t r;
        r = rand_fields();
        if (pick < 78) r.req = REQ_SETCUR;
        else if (pick < 88) r.req = REQ_READ;
        else if (pick < 94) r.req = REQ_COLOR;
        else if (pick < 96) r.req = REQ_SCROLL;
        else if (pick < 97) r.req = REQ_CLEAR;
        // else: leave the random code, including the reserved ones
        if (r.req == REQ_SCROLL && $urandom_range(0, 7) != 0)
          r.lines = 5'($urandom_range(0, 3));
        if (r.req == REQ_CLEAR && $urandom_range(0, 1) == 0) r.req = REQ_READ;
        send_req(r);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: ready pattern switches among always, random and periodic; a long
  // hold-off window lets results back up until the input stalls.
  // ---------------------------------------------------------------------
  logic hold_off = 1'b0;
  int   rx_cycle = 0;
  int   rx_mode = 0;

  always @(posedge clk_i) begin
    console_res_t e;
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) rx_mode <= $urandom_range(0, 2);
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_off) out_ready_i <= 1'b0;
    else if (rx_mode == 0) out_ready_i <= 1'b1;
    else if (rx_mode == 1) out_ready_i <= 1'($urandom);
    else out_ready_i <= (rx_cycle % 5) != 0;

    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat col=%0d row=%0d", $time,
                 cursor_col_o, cursor_row_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if ({cursor_col_o, cursor_row_o, cursor_linear_o, cursor_written_o,
             cell_char_o, cell_attr_o} !== {e.col, e.row, e.lin, e.wr, e.ch, e.attr}) begin
          $display("%0t: mismatch exp col=%0d row=%0d lin=%0d wr=%0d ch=%h attr=%h",
                   $time, e.col, e.row, e.lin, e.wr, e.ch, e.attr);
          $display("%0t:          act col=%0d row=%0d lin=%0d wr=%0d ch=%h attr=%h",
                   $time, cursor_col_o, cursor_row_o, cursor_linear_o,
                   cursor_written_o, cell_char_o, cell_attr_o);
          errors++;
        end
      end
    end
  end

  // long receiver stall once the random traffic is under way
  initial begin
    wait (beats_sent >= 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3000) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    foreach (shadow_screen[i]) shadow_screen[i] = '0;
    shadow_col = 0;
    shadow_row = 0;
    shadow_fg = 4'd15;
    shadow_bg = 4'd0;
    shadow_esc = ESC_NONE;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);   // block clears its screen store; ready stays low

    test_byte_classes();
    test_color_escapes();
    test_cursor_and_screen();
    test_random_traffic();

    // drop valid at the edge of the last accepted beat
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
